// ----- src/tcb_spline_key_tangents_assert.svh -----
// Assertion macros for the TCB tangent block.
`ifndef TCB_SPLINE_KEY_TANGENTS_ASSERT_SVH
`define TCB_SPLINE_KEY_TANGENTS_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TCBKT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TCBKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCBKT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define TCBKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/tcbkt_pkg.sv -----
`default_nettype none
package tcbkt_pkg;

    localparam int FRAME_BITS = 16;
    localparam int GAP_W      = FRAME_BITS + 2;
    localparam int PQ         = 14;
    localparam int DIV_N      = GAP_W - 1 + PQ + 1;
    localparam int NST        = DIV_N + 9;

    localparam logic signed [16:0] PONE = 17'sd16384;
    localparam logic signed [29:0] FSAT = 30'sd268435456;

    typedef enum logic [2:0] {
        CMD_INTERIOR   = 3'd0,
        CMD_FIRST_OPEN = 3'd1,
        CMD_LAST_OPEN  = 3'd2,
        CMD_FIRST_LOOP = 3'd3,
        CMD_LAST_LOOP  = 3'd4,
        CMD_TWO_KEY    = 3'd5
    } cmd_e;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               dzero;
        logic signed [16:0] tm;
        logic signed [16:0] ntm;
        logic signed [15:0] c;
        logic signed [15:0] b;
        logic signed [32:0] delm;
        logic signed [32:0] delp;
        logic signed [31:0] nb;
    } carry_t;

    typedef struct packed {
        logic [DIV_N-1:0] n;
        logic [DIV_N-1:0] q;
        logic [GAP_W-1:0] r;
        logic [GAP_W-1:0] dv;
        logic             neg;
    } lane_t;

    typedef struct packed {
        carry_t k;
        lane_t  la;
        lane_t  lg;
    } div_t;

    typedef struct packed {
        carry_t             k;
        logic signed [29:0] fp;
        logic signed [29:0] fn;
        logic [16:0]        fc;
        logic signed [15:0] omfc;
        logic signed [16:0] cm;
        logic signed [16:0] cp;
        logic signed [16:0] bm;
        logic signed [16:0] bp;
        logic signed [33:0] tmcm;
        logic signed [33:0] tmcp;
        logic signed [45:0] pcp;
        logic signed [45:0] pcn;
        logic signed [50:0] gp_sm;
        logic signed [50:0] gp_sp;
        logic signed [50:0] gp_dm;
        logic signed [50:0] gp_dp;
        logic signed [19:0] g_sm;
        logic signed [19:0] g_sp;
        logic signed [19:0] g_dm;
        logic signed [19:0] g_dp;
        logic signed [49:0] gf_sm;
        logic signed [49:0] gf_sp;
        logic signed [49:0] gf_dm;
        logic signed [49:0] gf_dp;
        logic signed [29:0] k_sm;
        logic signed [29:0] k_sp;
        logic signed [29:0] k_dm;
        logic signed [29:0] k_dp;
        logic signed [35:0] x;
        logic signed [65:0] pr0;
        logic signed [65:0] pr1;
        logic signed [65:0] pr2;
        logic signed [65:0] pr3;
        logic signed [66:0] s_in;
        logic signed [66:0] s_out;
    } post_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] in_t;
        logic signed [31:0] out_t;
        logic signed [31:0] nx_t;
    } res_t;

    // one restoring step: one quotient bit
    function automatic lane_t div_step(lane_t x);
        lane_t          y;
        logic [GAP_W:0] t;
        t = {x.r, x.n[DIV_N-1]};
        y = x;
        y.n = {x.n[DIV_N-2:0], 1'b0};
        if (t >= {1'b0, x.dv})
        begin
            y.r = GAP_W'(t - {1'b0, x.dv});
            y.q = {x.q[DIV_N-2:0], 1'b1};
        end
        else
        begin
            y.r = t[GAP_W-1:0];
            y.q = {x.q[DIV_N-2:0], 1'b0};
        end
        return y;
    endfunction

    // signed quotient, clipped to +-2^28
    function automatic logic signed [29:0] quot_sat(logic [DIV_N-1:0] q, logic neg);
        logic [28:0]        m;
        logic signed [29:0] s;
        m = (q > DIV_N'(29'h1000_0000)) ? 29'h1000_0000 : q[28:0];
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    function automatic logic signed [29:0] sat_q28(logic signed [63:0] x);
        logic signed [29:0] r;
        if (x > 64'sd268435456)
            r = FSAT;
        else if (x < -64'sd268435456)
            r = -FSAT;
        else
            r = x[29:0];
        return r;
    endfunction

    // round half up by 14 or 15 bits, then clip to 32 bits
    function automatic logic signed [31:0] rnd_sat32(logic signed [66:0] s, logic sh15);
        logic signed [66:0] t;
        logic signed [31:0] r;
        t = s + (sh15 ? 67'sd16384 : 67'sd8192);
        t = sh15 ? (t >>> 15) : (t >>> 14);
        if (t > 67'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (t < -67'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = t[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/tcb_spline_key_tangents.sv -----
`default_nettype none
// TCB (Kochanek-Bartels) key tangents, one key and one axis per item.
// Input channel s_axis: tdata carries frames, tension/continuity/bias and
// values of the previous, current and next key plus a neighbour tangent;
// tuser carries the command (interior, open ends, looped ends, two-key).
// Output channel m_axis: incoming, outgoing and next-incoming tangent.
// cfg_wr_en/cfg_wr_data write the loop length; write only while idle.
// Throughput: one item per cycle while the skid entry is empty. Items pass
// through the 32-stage radix-2 spacing-factor divider and then eight
// multiply/round stages.
// All stages advance together; a two-entry output (register plus skid)
// lets the block keep taking items after the receiver stalls until a stalled
// result fills the skid entry; s_axis_tready then stays low until it drains.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the
// loop length to zero; no item is lost or repeated across a stall.
`include "tcb_spline_key_tangents_assert.svh"
module tcb_spline_key_tangents (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,     // segment_length
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] prev_frame, [31:16] this_frame, [47:32] next_frame,
    // [63:48] tension, [79:64] continuity, [95:80] bias,
    // [111:96] next_tension, [143:112] prev_value, [175:144] this_value,
    // [207:176] next_value, [239:208] neighbour_tangent
    input  wire logic [239:0] s_axis_tdata,
    input  wire logic [2:0]   s_axis_tuser,    // [2:0] command
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] incoming_tangent, [63:32] outgoing_tangent,
    // [95:64] next_incoming_tangent
    output logic [95:0]       m_axis_tdata
);

    localparam int DN  = tcbkt_pkg::DIV_N;
    localparam int NS  = tcbkt_pkg::NST;
    localparam int GW  = tcbkt_pkg::GAP_W;
    localparam int FB  = tcbkt_pkg::FRAME_BITS;

    logic [15:0]       seg_reg;
    logic [NS-1:0]     valid_reg;
    tcbkt_pkg::div_t   div_reg [0:DN];
    tcbkt_pkg::div_t   prep_next;
    tcbkt_pkg::post_t  p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg;
    tcbkt_pkg::post_t  p1_next, p2_next, p3_next, p4_next, p5_next, p6_next, p7_next;
    tcbkt_pkg::res_t   res_reg, res_next, out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              adv, in_acc, pipe_out, out_free;

    // whole pipe moves while the skid entry is free
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;
    assign pipe_out      = valid_reg[NS-1] && adv;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= '0;
        else if (cfg_wr_en)
            seg_reg <= cfg_wr_data;
    end

    // ---- input prep: frame gaps, divider operands, deltas
    always_comb
    begin
        logic [2:0]            cmd;
        logic signed [GW-1:0]  pf, tf, nf, sg, a, g, am, gm;
        logic signed [GW:0]    d, dm;
        logic signed [31:0]    pv, tv, nv;
        logic signed [15:0]    t, nt;
        cmd = s_axis_tuser;
        pf  = $signed(GW'(s_axis_tdata[FB-1:0]));
        tf  = $signed(GW'(s_axis_tdata[16+FB-1:16]));
        nf  = $signed(GW'(s_axis_tdata[32+FB-1:32]));
        sg  = $signed(GW'(seg_reg));
        t   = $signed(s_axis_tdata[63:48]);
        nt  = $signed(s_axis_tdata[111:96]);
        pv  = $signed(s_axis_tdata[143:112]);
        tv  = $signed(s_axis_tdata[175:144]);
        nv  = $signed(s_axis_tdata[207:176]);
        a   = tf - pf + ((cmd == tcbkt_pkg::CMD_FIRST_LOOP) ? sg : '0);
        g   = nf - tf + ((cmd == tcbkt_pkg::CMD_LAST_LOOP) ? sg : '0);
        d   = (GW+1)'(a) + (GW+1)'(g);
        am  = (a < 0) ? -a : a;
        gm  = (g < 0) ? -g : g;
        dm  = (d < 0) ? -d : d;

        prep_next.k.cmd   = cmd;
        prep_next.k.dzero = (d == 0);
        prep_next.k.tm    = tcbkt_pkg::PONE - 17'(t);
        prep_next.k.ntm   = tcbkt_pkg::PONE - 17'(nt);
        prep_next.k.c     = $signed(s_axis_tdata[79:64]);
        prep_next.k.b     = $signed(s_axis_tdata[95:80]);
        prep_next.k.delm  = 33'(tv) - 33'(pv);
        prep_next.k.delp  = 33'(nv) - 33'(tv);
        prep_next.k.nb    = $signed(s_axis_tdata[239:208]);

        prep_next.la.n   = {am[GW-2:0], {(tcbkt_pkg::PQ+1){1'b0}}};
        prep_next.la.q   = '0;
        prep_next.la.r   = '0;
        prep_next.la.dv  = (d == 0) ? GW'(1) : dm[GW-1:0];
        prep_next.la.neg = a[GW-1] ^ d[GW];
        prep_next.lg.n   = {gm[GW-2:0], {(tcbkt_pkg::PQ+1){1'b0}}};
        prep_next.lg.q   = '0;
        prep_next.lg.r   = '0;
        prep_next.lg.dv  = (d == 0) ? GW'(1) : dm[GW-1:0];
        prep_next.lg.neg = g[GW-1] ^ d[GW];
    end

    // ---- divider: one quotient bit per stage, both gaps side by side
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= prep_next;
            for (int i = 1; i <= DN; i++)
            begin
                div_reg[i].k  <= div_reg[i-1].k;
                div_reg[i].la <= tcbkt_pkg::div_step(div_reg[i-1].la);
                div_reg[i].lg <= tcbkt_pkg::div_step(div_reg[i-1].lg);
            end
        end
    end

    // P1: clip quotients, parameter terms, tm*c products
    always_comb
    begin
        logic signed [16:0] cx, bx;
        p1_next       = '0;
        p1_next.k     = div_reg[DN].k;
        p1_next.fp    = tcbkt_pkg::quot_sat(div_reg[DN].la.q, div_reg[DN].la.neg);
        p1_next.fn    = tcbkt_pkg::quot_sat(div_reg[DN].lg.q, div_reg[DN].lg.neg);
        cx            = 17'(div_reg[DN].k.c);
        bx            = 17'(div_reg[DN].k.b);
        p1_next.fc    = (cx < 0) ? 17'(-cx) : 17'(cx);
        p1_next.omfc  = 16'(18'sd16384 - $signed({1'b0, p1_next.fc}));
        p1_next.cm    = tcbkt_pkg::PONE - cx;
        p1_next.cp    = tcbkt_pkg::PONE + cx;
        p1_next.bm    = tcbkt_pkg::PONE - bx;
        p1_next.bp    = tcbkt_pkg::PONE + bx;
        p1_next.tmcm  = div_reg[DN].k.tm * p1_next.cm;
        p1_next.tmcp  = div_reg[DN].k.tm * p1_next.cp;
    end

    // P2: continuity scaling of the factors, triple products
    always_comb
    begin
        p2_next       = p1_reg;
        p2_next.pcp   = p1_reg.fp * p1_reg.omfc;
        p2_next.pcn   = p1_reg.fn * p1_reg.omfc;
        p2_next.gp_sm = p1_reg.tmcm * p1_reg.bp;
        p2_next.gp_sp = p1_reg.tmcp * p1_reg.bm;
        p2_next.gp_dm = p1_reg.tmcp * p1_reg.bp;
        p2_next.gp_dp = p1_reg.tmcm * p1_reg.bm;
    end

    // P3: final spacing factors (1.0 for a zero gap sum), rounded triples
    always_comb
    begin
        logic signed [63:0] tp, tn;
        p3_next = p2_reg;
        tp = ((64'(p2_reg.pcp) + 64'sd8192) >>> 14) + $signed({47'b0, p2_reg.fc});
        tn = ((64'(p2_reg.pcn) + 64'sd8192) >>> 14) + $signed({47'b0, p2_reg.fc});
        p3_next.fp   = p2_reg.k.dzero ? 30'(tcbkt_pkg::PONE) : tcbkt_pkg::sat_q28(tp);
        p3_next.fn   = p2_reg.k.dzero ? 30'(tcbkt_pkg::PONE) : tcbkt_pkg::sat_q28(tn);
        p3_next.g_sm = 20'((p2_reg.gp_sm + 51'sd268435456) >>> 29);
        p3_next.g_sp = 20'((p2_reg.gp_sp + 51'sd268435456) >>> 29);
        p3_next.g_dm = 20'((p2_reg.gp_dm + 51'sd268435456) >>> 29);
        p3_next.g_dp = 20'((p2_reg.gp_dp + 51'sd268435456) >>> 29);
    end

    // P4: coefficient products
    always_comb
    begin
        p4_next       = p3_reg;
        p4_next.gf_sm = p3_reg.g_sm * p3_reg.fp;
        p4_next.gf_sp = p3_reg.g_sp * p3_reg.fp;
        p4_next.gf_dm = p3_reg.g_dm * p3_reg.fn;
        p4_next.gf_dp = p3_reg.g_dp * p3_reg.fn;
    end

    // P5: coefficients; open-end term 3*del - neighbour
    always_comb
    begin
        logic signed [32:0] dsel;
        p5_next      = p4_reg;
        p5_next.k_sm = tcbkt_pkg::sat_q28((64'(p4_reg.gf_sm) + 64'sd8192) >>> 14);
        p5_next.k_sp = tcbkt_pkg::sat_q28((64'(p4_reg.gf_sp) + 64'sd8192) >>> 14);
        p5_next.k_dm = tcbkt_pkg::sat_q28((64'(p4_reg.gf_dm) + 64'sd8192) >>> 14);
        p5_next.k_dp = tcbkt_pkg::sat_q28((64'(p4_reg.gf_dp) + 64'sd8192) >>> 14);
        dsel = (p4_reg.k.cmd == tcbkt_pkg::CMD_FIRST_OPEN) ? p4_reg.k.delp : p4_reg.k.delm;
        p5_next.x = 36'(dsel) * 36'sd3 - 36'(p4_reg.k.nb);
    end

    // P6: operand select per command, four products
    always_comb
    begin
        logic signed [35:0] a0, a1, a2, a3;
        logic signed [29:0] b0, b1, b2, b3;
        a0 = '0; a1 = '0; a2 = '0; a3 = '0;
        b0 = '0; b1 = '0; b2 = '0; b3 = '0;
        case (p5_reg.k.cmd) inside
            tcbkt_pkg::CMD_INTERIOR, tcbkt_pkg::CMD_FIRST_LOOP, tcbkt_pkg::CMD_LAST_LOOP:
            begin
                a0 = 36'(p5_reg.k.delm); b0 = p5_reg.k_sm;
                a1 = 36'(p5_reg.k.delp); b1 = p5_reg.k_sp;
                a2 = 36'(p5_reg.k.delm); b2 = p5_reg.k_dm;
                a3 = 36'(p5_reg.k.delp); b3 = p5_reg.k_dp;
            end
            tcbkt_pkg::CMD_FIRST_OPEN:
            begin
                a2 = p5_reg.x; b2 = 30'(p5_reg.k.tm);
            end
            tcbkt_pkg::CMD_LAST_OPEN:
            begin
                a0 = p5_reg.x; b0 = 30'(p5_reg.k.tm);
            end
            tcbkt_pkg::CMD_TWO_KEY:
            begin
                // lane 0 carries the next key's tangent
                a0 = 36'(p5_reg.k.delp); b0 = 30'(p5_reg.k.ntm);
                a2 = 36'(p5_reg.k.delp); b2 = 30'(p5_reg.k.tm);
            end
            default:
            begin
                a0 = '0;
            end
        endcase
        p6_next     = p5_reg;
        p6_next.pr0 = a0 * b0;
        p6_next.pr1 = a1 * b1;
        p6_next.pr2 = a2 * b2;
        p6_next.pr3 = a3 * b3;
    end

    // P7: sums
    always_comb
    begin
        p7_next       = p6_reg;
        p7_next.s_in  = 67'(p6_reg.pr0) + 67'(p6_reg.pr1);
        p7_next.s_out = 67'(p6_reg.pr2) + 67'(p6_reg.pr3);
    end

    // P8: rounding, clipping, field placement
    always_comb
    begin
        res_next.cmd   = p7_reg.k.cmd;
        res_next.in_t  = '0;
        res_next.out_t = '0;
        res_next.nx_t  = '0;
        case (p7_reg.k.cmd) inside
            tcbkt_pkg::CMD_INTERIOR, tcbkt_pkg::CMD_FIRST_LOOP, tcbkt_pkg::CMD_LAST_LOOP:
            begin
                res_next.in_t  = tcbkt_pkg::rnd_sat32(p7_reg.s_in, 1'b0);
                res_next.out_t = tcbkt_pkg::rnd_sat32(p7_reg.s_out, 1'b0);
            end
            tcbkt_pkg::CMD_FIRST_OPEN:
                res_next.out_t = tcbkt_pkg::rnd_sat32(p7_reg.s_out, 1'b1);
            tcbkt_pkg::CMD_LAST_OPEN:
                res_next.in_t  = tcbkt_pkg::rnd_sat32(p7_reg.s_in, 1'b1);
            tcbkt_pkg::CMD_TWO_KEY:
            begin
                res_next.out_t = tcbkt_pkg::rnd_sat32(p7_reg.s_out, 1'b0);
                res_next.nx_t  = tcbkt_pkg::rnd_sat32(p7_reg.s_in, 1'b0);
            end
            default:
                res_next.in_t = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            p6_reg  <= p6_next;
            p7_reg  <= p7_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NS-2:0], in_acc};
    end

    // ---- output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= pipe_out;
        end
        else if (pipe_out)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        else if (pipe_out)
            skid_reg <= res_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.nx_t, out_reg.out_t, out_reg.in_t};

    // ---- checks
    `TCBKT_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `TCBKT_ASSERT_IMPLY(a_nx_zero, clk, rst_n,
        out_valid_reg && (out_reg.cmd != tcbkt_pkg::CMD_TWO_KEY), out_reg.nx_t == 32'sd0,
        "next incoming tangent non-zero outside two-key mode")
    `TCBKT_ASSERT_IMPLY(a_div_rem, clk, rst_n, valid_reg[DN],
        div_reg[DN].la.r < div_reg[DN].la.dv, "divider remainder not below divisor")
    `TCBKT_ASSERT_NEXT(a_skid_catch, clk, rst_n, pipe_out && !out_free, skid_valid_reg,
        "stalled result not caught by skid entry")

endmodule
`default_nettype wire
